### rtl/core/assert_macros.svh
// Assertion helper macros shared by the monitor RTL.
// No dependencies; the property forms compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted
`define LRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
// Next-cycle implication, disabled while reset is asserted
`define LRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define LRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/lrshm_pkg.sv
// Shared types, constants and helpers of the loop reject spike health monitor.
// No dependencies.
package lrshm_pkg;

	localparam int unsigned WINDOW_DEPTH_DEF = 8;
	localparam int unsigned RATE_W           = 17;
	localparam int unsigned CNT_W            = 32;
	localparam int unsigned FIELD_W          = 16;
	localparam int unsigned CD_W             = 8;
	localparam int unsigned CFG_IDX_W        = 3;
	localparam int unsigned CFG_DATA_W       = 17;
	localparam int unsigned QUO_STEPS        = 17;

	localparam logic [RATE_W-1:0] ONE_Q16 = 17'h10000;

	// Register reset values
	localparam logic [FIELD_W-1:0] DROP_MIN_RST   = 16'd30;
	localparam logic [RATE_W-1:0]  DROP_RATE_RST  = 17'd29491;
	localparam logic [FIELD_W-1:0] SPIKE_MIN_RST  = 16'd4;
	localparam logic [RATE_W-1:0]  SPIKE_ABS_RST  = 17'd52429;
	localparam logic [RATE_W-1:0]  SPIKE_JUMP_RST = 17'd22938;
	localparam logic [CD_W-1:0]    COOLDOWN_RST   = 8'd5;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DROP_MIN,
		CFG_DROP_RATE,
		CFG_SPIKE_MIN,
		CFG_SPIKE_ABS,
		CFG_SPIKE_JUMP,
		CFG_COOLDOWN
	} cfg_idx_t;

	typedef enum logic [1:0] {
		OP_BATCH,
		OP_LOOP,
		OP_KEYFRAME,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		DIV_ACC,
		DIV_DRP,
		DIV_REJ,
		DIV_CYC,
		DIV_MEAN
	} div_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_LAUNCH,
		ST_ACC,
		ST_DRP,
		ST_REJ,
		ST_CYC,
		ST_MEAN,
		ST_PUSH,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic     take;
		logic     update;
		logic     div_start;
		div_sel_t div_sel;
		logic     win_read;
		logic     push;
		logic     respond;
	} ctl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic att_nz;
		logic cand_tot_nz;
		logic cand_nz;
		logic fill_nz;
		logic div_done;
		logic out_free;
	} ctl_stat_t;

	function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
			input logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction

endpackage

### rtl/core/lrshm_ifs.sv
// Valid/ready channel interfaces for the monitor's event input and status output.
// Depends on lrshm_pkg for field widths.
interface lrshm_in_if;
	import lrshm_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [FIELD_W-1:0] attempted;
	logic [FIELD_W-1:0] accepted;
	logic [FIELD_W-1:0] candidates;
	logic [FIELD_W-1:0] rejected;

	modport source (output valid, op, attempted, accepted, candidates, rejected,
		input ready);
	modport sink (input valid, op, attempted, accepted, candidates, rejected,
		output ready);
endinterface

interface lrshm_out_if;
	import lrshm_pkg::*;
	logic              valid;
	logic              ready;
	logic              drop_warning;
	logic [RATE_W-1:0] acceptance_rate;
	logic [RATE_W-1:0] drop_rate;
	logic [RATE_W-1:0] loop_reject_rate;
	logic              spike_detected;
	logic [CNT_W-1:0]  spike_total;
	logic [RATE_W-1:0] cycle_reject_ratio;
	logic [RATE_W-1:0] rolling_baseline;
	logic [CD_W-1:0]   cooldown_left;
	logic              closures_enabled;
	logic              cooldown_expired;

	modport source (output valid, drop_warning, acceptance_rate, drop_rate,
		loop_reject_rate, spike_detected, spike_total, cycle_reject_ratio,
		rolling_baseline, cooldown_left, closures_enabled, cooldown_expired,
		input ready);
	modport sink (input valid, drop_warning, acceptance_rate, drop_rate,
		loop_reject_rate, spike_detected, spike_total, cycle_reject_ratio,
		rolling_baseline, cooldown_left, closures_enabled, cooldown_expired,
		output ready);
endinterface

### rtl/core/lrshm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrshm_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 8,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

### rtl/core/lrshm_div.sv
// Restoring serial divider giving a Q1.16 quotient, one bit per cycle.
// Depends on lrshm_pkg; the numerator must not exceed the denominator.
module lrshm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [lrshm_pkg::CNT_W-1:0] num,
	input  logic [lrshm_pkg::CNT_W-1:0] den,
	output logic                       done,
	output logic [lrshm_pkg::RATE_W-1:0] quo
);
	import lrshm_pkg::*;

	localparam int unsigned STEP_W = $clog2(QUO_STEPS);

	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  den_q;
	logic [RATE_W-1:0] quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [CNT_W+1:0]  diff;
	logic              ge;
	logic [CNT_W:0]    rem_new;

	// Trial subtract of the denominator
	assign diff    = {1'b0, rem_q} - {2'b0, den_q};
	assign ge      = ~diff[CNT_W+1];
	assign rem_new = ge ? diff[CNT_W:0] : rem_q;

	// Sequence the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(QUO_STEPS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - STEP_W'(1);
				end
			end
		end
	end

	// Remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_new[CNT_W-1:0], 1'b0};
			quo_q <= {quo_q[RATE_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = (quo_q > ONE_Q16) ? ONE_Q16 : quo_q;
endmodule

### rtl/core/lrshm_ctrl.sv
// Controller state machine of the monitor: sequences updates, divisions and replies.
// Depends on lrshm_pkg for the state, command and status types.
module lrshm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  lrshm_pkg::ctl_stat_t  stat,
	output lrshm_pkg::ctl_cmd_t   cmd
);
	import lrshm_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_ACC;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_LAUNCH;
			end
			ST_LAUNCH: begin
				unique case (stat.op)
					OP_BATCH: begin
						if (stat.att_nz) begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DIV_ACC;
							state_d       = ST_ACC;
						end else begin
							state_d = ST_RESP;
						end
					end
					OP_LOOP: begin
						if (stat.cand_tot_nz) begin
							cmd.div_start = 1'b1;
							cmd.div_sel   = DIV_REJ;
							state_d       = ST_REJ;
						end else begin
							state_d = ST_RESP;
						end
					end
					default: begin
						state_d = ST_RESP;
					end
				endcase
			end
			ST_ACC: begin
				if (stat.div_done) begin
					cmd.div_start = 1'b1;
					cmd.div_sel   = DIV_DRP;
					state_d       = ST_DRP;
				end
			end
			ST_DRP: begin
				if (stat.div_done) begin
					state_d = ST_RESP;
				end
			end
			ST_REJ: begin
				if (stat.div_done) begin
					if (stat.cand_nz) begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_CYC;
						state_d       = ST_CYC;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_CYC: begin
				if (stat.div_done) begin
					// fetch the slot about to be overwritten
					cmd.win_read = 1'b1;
					if (stat.fill_nz) begin
						cmd.div_start = 1'b1;
						cmd.div_sel   = DIV_MEAN;
						state_d       = ST_MEAN;
					end else begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_MEAN: begin
				if (stat.div_done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.respond = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

### rtl/core/lrshm_dp.sv
// Datapath of the monitor: registers, totals, ratio window, divider and output beat.
// Depends on lrshm_pkg, lrshm_div and lrshm_ram.
module lrshm_dp #(
	parameter int unsigned WINDOW_DEPTH = lrshm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lrshm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lrshm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  lrshm_pkg::ctl_cmd_t                 cmd,
	output lrshm_pkg::ctl_stat_t                stat,
	input  logic [1:0]                          op,
	input  logic [lrshm_pkg::FIELD_W-1:0]       attempted,
	input  logic [lrshm_pkg::FIELD_W-1:0]       accepted,
	input  logic [lrshm_pkg::FIELD_W-1:0]       candidates,
	input  logic [lrshm_pkg::FIELD_W-1:0]       rejected,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                drop_warning,
	output logic [lrshm_pkg::RATE_W-1:0]        acceptance_rate,
	output logic [lrshm_pkg::RATE_W-1:0]        drop_rate,
	output logic [lrshm_pkg::RATE_W-1:0]        loop_reject_rate,
	output logic                                spike_detected,
	output logic [lrshm_pkg::CNT_W-1:0]         spike_total,
	output logic [lrshm_pkg::RATE_W-1:0]        cycle_reject_ratio,
	output logic [lrshm_pkg::RATE_W-1:0]        rolling_baseline,
	output logic [lrshm_pkg::CD_W-1:0]          cooldown_left,
	output logic                                closures_enabled,
	output logic                                cooldown_expired
);
	import lrshm_pkg::*;

	localparam int unsigned FW = $clog2(WINDOW_DEPTH + 1);
	localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int unsigned SW = RATE_W + FW;

	// Configuration registers
	logic [FIELD_W-1:0] drop_min_q;
	logic [RATE_W-1:0]  drop_rate_cfg_q;
	logic [FIELD_W-1:0] spike_min_q;
	logic [RATE_W-1:0]  spike_abs_q;
	logic [RATE_W-1:0]  spike_jump_q;
	logic [CD_W-1:0]    cooldown_cfg_q;

	// Held item
	logic [1:0]         op_q;
	logic [FIELD_W-1:0] att_q;
	logic [FIELD_W-1:0] acc_q;
	logic [FIELD_W-1:0] cand_q;
	logic [FIELD_W-1:0] rej_q;

	// Monitor state
	logic [CNT_W-1:0]  tot_att_q;
	logic [CNT_W-1:0]  tot_acc_q;
	logic [CNT_W-1:0]  tot_drp_q;
	logic [RATE_W-1:0] acc_rate_q;
	logic [RATE_W-1:0] drp_rate_q;
	logic [CNT_W-1:0]  tot_cand_q;
	logic [CNT_W-1:0]  tot_rej_q;
	logic [RATE_W-1:0] rej_rate_q;
	logic [RATE_W-1:0] ratio_q;
	logic [RATE_W-1:0] base_q;
	logic              spike_q;
	logic              expired_q;
	logic [CNT_W-1:0]  spike_cnt_q;
	logic [CD_W-1:0]   cool_q;
	logic [AW-1:0]     head_q;
	logic [FW-1:0]     fill_q;
	logic [SW-1:0]     sum_q;
	div_sel_t          sel_q;

	// Output beat
	logic              out_valid_q;
	logic              warn_q;
	logic [RATE_W-1:0] acc_rate_o_q;
	logic [RATE_W-1:0] drp_rate_o_q;
	logic [RATE_W-1:0] rej_rate_o_q;
	logic              spike_o_q;
	logic [CNT_W-1:0]  spike_cnt_o_q;
	logic [RATE_W-1:0] ratio_o_q;
	logic [RATE_W-1:0] base_o_q;
	logic [CD_W-1:0]   cool_o_q;
	logic              expired_o_q;

	// Divider and window wires
	logic [CNT_W-1:0]  div_num;
	logic [CNT_W-1:0]  div_den;
	logic              div_done;
	logic [RATE_W-1:0] div_quo;
	logic [RATE_W-1:0] old_ratio;
	logic              win_full;
	logic              spike_w;
	logic              warn_w;
	logic [RATE_W:0]   jump_sum;

	// Configuration writes; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_min_q      <= DROP_MIN_RST;
			drop_rate_cfg_q <= DROP_RATE_RST;
			spike_min_q     <= SPIKE_MIN_RST;
			spike_abs_q     <= SPIKE_ABS_RST;
			spike_jump_q    <= SPIKE_JUMP_RST;
			cooldown_cfg_q  <= COOLDOWN_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DROP_MIN:   drop_min_q      <= cfg_data[FIELD_W-1:0];
				CFG_DROP_RATE:  drop_rate_cfg_q <= cfg_data[RATE_W-1:0];
				CFG_SPIKE_MIN:  spike_min_q     <= cfg_data[FIELD_W-1:0];
				CFG_SPIKE_ABS:  spike_abs_q     <= cfg_data[RATE_W-1:0];
				CFG_SPIKE_JUMP: spike_jump_q    <= cfg_data[RATE_W-1:0];
				CFG_COOLDOWN:   cooldown_cfg_q  <= cfg_data[CD_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the item, clamping accepted and rejected counts
	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= op;
			att_q  <= attempted;
			acc_q  <= (accepted > attempted) ? attempted : accepted;
			cand_q <= candidates;
			rej_q  <= (rejected > candidates) ? candidates : rejected;
		end
	end

	// Divider operand selection
	always_comb begin
		unique case (cmd.div_sel)
			DIV_ACC: begin
				div_num = tot_acc_q;
				div_den = tot_att_q;
			end
			DIV_DRP: begin
				div_num = tot_drp_q;
				div_den = tot_att_q;
			end
			DIV_REJ: begin
				div_num = tot_rej_q;
				div_den = tot_cand_q;
			end
			DIV_CYC: begin
				div_num = CNT_W'(rej_q);
				div_den = CNT_W'(cand_q);
			end
			DIV_MEAN: begin
				// sum / (fill << 16) in Q1.16 is the plain integer mean
				div_num = CNT_W'(sum_q);
				div_den = CNT_W'({fill_q, 16'h0000});
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	lrshm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	lrshm_ram #(
		.WIDTH (RATE_W),
		.DEPTH (WINDOW_DEPTH)
	) u_win (
		.clk   (clk),
		.we    (cmd.push),
		.waddr (head_q),
		.wdata (ratio_q),
		.re    (cmd.win_read),
		.raddr (head_q),
		.rdata (old_ratio)
	);

	// Spike test against the baseline of the window before this push
	assign win_full = (fill_q == FW'(WINDOW_DEPTH));
	assign jump_sum = {1'b0, base_q} + {1'b0, spike_jump_q};
	assign spike_w  = (cand_q >= spike_min_q) && (fill_q != '0) &&
		(ratio_q >= spike_abs_q) && ({1'b0, ratio_q} >= jump_sum);
	assign warn_w   = (op_t'(op_q) == OP_BATCH) &&
		(tot_att_q >= CNT_W'(drop_min_q)) && (drp_rate_q >= drop_rate_cfg_q);

	// Monitor state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_att_q   <= '0;
			tot_acc_q   <= '0;
			tot_drp_q   <= '0;
			acc_rate_q  <= '0;
			drp_rate_q  <= '0;
			tot_cand_q  <= '0;
			tot_rej_q   <= '0;
			rej_rate_q  <= '0;
			ratio_q     <= '0;
			base_q      <= '0;
			spike_q     <= 1'b0;
			expired_q   <= 1'b0;
			spike_cnt_q <= '0;
			cool_q      <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			sum_q       <= '0;
			sel_q       <= DIV_ACC;
		end else begin
			// clear the per-item flags
			if (cmd.take) begin
				ratio_q   <= '0;
				base_q    <= '0;
				spike_q   <= 1'b0;
				expired_q <= 1'b0;
			end
			// add the item to the totals or step the cooldown
			if (cmd.update) begin
				unique case (op_t'(op_q))
					OP_BATCH: begin
						tot_att_q <= sat_add32(tot_att_q, CNT_W'(att_q));
						tot_acc_q <= sat_add32(tot_acc_q, CNT_W'(acc_q));
						tot_drp_q <= sat_add32(tot_drp_q, CNT_W'(att_q - acc_q));
					end
					OP_LOOP: begin
						tot_cand_q <= sat_add32(tot_cand_q, CNT_W'(cand_q));
						tot_rej_q  <= sat_add32(tot_rej_q, CNT_W'(rej_q));
					end
					OP_KEYFRAME: begin
						if (cool_q != '0) begin
							cool_q    <= cool_q - CD_W'(1);
							expired_q <= (cool_q == CD_W'(1));
						end
					end
					default: ;
				endcase
			end
			// route division results
			if (cmd.div_start) begin
				sel_q <= cmd.div_sel;
			end
			if (div_done) begin
				unique case (sel_q)
					DIV_ACC:  acc_rate_q <= div_quo;
					DIV_DRP:  drp_rate_q <= div_quo;
					DIV_REJ:  rej_rate_q <= div_quo;
					DIV_CYC:  ratio_q    <= div_quo;
					DIV_MEAN: base_q     <= div_quo;
					default: ;
				endcase
			end
			// push the ratio, evicting the oldest entry once full
			if (cmd.push) begin
				spike_q <= spike_w;
				if (spike_w) begin
					if (spike_cnt_q != {CNT_W{1'b1}}) begin
						spike_cnt_q <= spike_cnt_q + CNT_W'(1);
					end
					cool_q <= cooldown_cfg_q;
				end
				sum_q  <= sum_q - (win_full ? SW'(old_ratio) : SW'(0)) + SW'(ratio_q);
				head_q <= (head_q == AW'(WINDOW_DEPTH - 1)) ? '0 : head_q + AW'(1);
				if (!win_full) begin
					fill_q <= fill_q + FW'(1);
				end
			end
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.respond) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload
	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			warn_q        <= warn_w;
			acc_rate_o_q  <= acc_rate_q;
			drp_rate_o_q  <= drp_rate_q;
			rej_rate_o_q  <= rej_rate_q;
			spike_o_q     <= spike_q;
			spike_cnt_o_q <= spike_cnt_q;
			ratio_o_q     <= ratio_q;
			base_o_q      <= base_q;
			cool_o_q      <= cool_q;
			expired_o_q   <= expired_q;
		end
	end

	assign stat.op          = op_t'(op_q);
	assign stat.att_nz      = (tot_att_q != '0);
	assign stat.cand_tot_nz = (tot_cand_q != '0);
	assign stat.cand_nz     = (cand_q != '0);
	assign stat.fill_nz     = (fill_q != '0);
	assign stat.div_done    = div_done;
	assign stat.out_free    = ~out_valid_q | out_ready;

	assign out_valid          = out_valid_q;
	assign drop_warning       = warn_q;
	assign acceptance_rate    = acc_rate_o_q;
	assign drop_rate          = drp_rate_o_q;
	assign loop_reject_rate   = rej_rate_o_q;
	assign spike_detected     = spike_o_q;
	assign spike_total        = spike_cnt_o_q;
	assign cycle_reject_ratio = ratio_o_q;
	assign rolling_baseline   = base_o_q;
	assign cooldown_left      = cool_o_q;
	assign closures_enabled   = (cool_o_q == '0);
	assign cooldown_expired   = expired_o_q;
endmodule

### rtl/core/loop_reject_spike_health_monitor.sv
// Loop reject spike health monitor, top level; depends on lrshm_pkg, lrshm_ifs,
// lrshm_ctrl, lrshm_dp and assert_macros.svh.
// Usage: one event beat enters on in_ch (op 0 batch, 1 loop cycle, 2 keyframe,
// 3 no event) and exactly one status beat leaves on out_ch for it. Thresholds
// are written through cfg_we/cfg_index/cfg_data while no event is in flight.
// Keyframe and no-event beats and events with nothing to divide go straight to
// the reply; a batch runs two divisions (acceptance and drop rate) and a loop
// cycle with candidates and a non-empty window runs three (reject rate, cycle
// ratio and window mean), each giving a 17-bit quotient in the shared serial
// divider. One event is in work at a time: the next beat is taken only once
// the status beat of the last one is loaded into the output register.
// The ratio window lives in a small RAM; a running sum gives the mean.
// Reset clears totals, rates, the window fill and the cooldown, and loads the
// default thresholds; no clearing pass is needed.
// A stalled out_ch holds its beat; the next event is still taken and worked
// and its result is held in the datapath until the output register frees.
`include "assert_macros.svh"
module loop_reject_spike_health_monitor #(
	parameter int unsigned WINDOW_DEPTH = lrshm_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lrshm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lrshm_pkg::CFG_DATA_W-1:0] cfg_data,
	lrshm_in_if.sink                         in_ch,
	lrshm_out_if.source                      out_ch
);
	import lrshm_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	lrshm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lrshm_dp #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.cmd                (cmd),
		.stat               (stat),
		.op                 (in_ch.op),
		.attempted          (in_ch.attempted),
		.accepted           (in_ch.accepted),
		.candidates         (in_ch.candidates),
		.rejected           (in_ch.rejected),
		.out_valid          (out_ch.valid),
		.out_ready          (out_ch.ready),
		.drop_warning       (out_ch.drop_warning),
		.acceptance_rate    (out_ch.acceptance_rate),
		.drop_rate          (out_ch.drop_rate),
		.loop_reject_rate   (out_ch.loop_reject_rate),
		.spike_detected     (out_ch.spike_detected),
		.spike_total        (out_ch.spike_total),
		.cycle_reject_ratio (out_ch.cycle_reject_ratio),
		.rolling_baseline   (out_ch.rolling_baseline),
		.cooldown_left      (out_ch.cooldown_left),
		.closures_enabled   (out_ch.closures_enabled),
		.cooldown_expired   (out_ch.cooldown_expired)
	);

	// One event in work at a time
	`LRS_ASSERT_NXT(a_single_event, clk, arst_n, in_ch.valid && in_ch.ready, !in_ch.ready)
	// A spike only fires when the ratio clears the baseline
	`LRS_ASSERT_IMP(a_spike_over_base, clk, arst_n, out_ch.valid && out_ch.spike_detected, out_ch.cycle_reject_ratio >= out_ch.rolling_baseline)
	// Acceptance and drop rates never exceed one in Q1.16
	`LRS_ASSERT_IMP(a_rate_bound, clk, arst_n, out_ch.valid, (out_ch.acceptance_rate <= ONE_Q16) && (out_ch.drop_rate <= ONE_Q16))
	// Expiry leaves the cooldown at zero
	`LRS_ASSERT_IMP(a_expiry_zero, clk, arst_n, out_ch.valid && out_ch.cooldown_expired, out_ch.closures_enabled && !out_ch.spike_detected)
endmodule
